>>> rtl/ngga_pkg.sv
// Shared types, character codes and limits for the GGA position parser.
`timescale 1ns / 1ps
`default_nettype none

package ngga_pkg;

    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_W     = 8'h57;

    localparam logic [3:0] HDR_LEN = 4'd6;

    localparam logic [4:0] FLD_HEADER  = 5'd0;
    localparam logic [4:0] FLD_LAT     = 5'd2;
    localparam logic [4:0] FLD_LAT_DIR = 5'd3;
    localparam logic [4:0] FLD_LON     = 5'd4;
    localparam logic [4:0] FLD_LON_DIR = 5'd5;
    localparam logic [4:0] FLD_FIX     = 5'd6;
    localparam logic [4:0] FLD_ALT     = 5'd9;
    localparam logic [4:0] FLD_MIN     = 5'd9;
    localparam logic [4:0] FLD_MAX     = 5'd31;

    localparam logic [3:0]  CHAR_CNT_MAX  = 4'd15;
    localparam logic [2:0]  FRAC_DIGITS   = 3'd5;
    localparam logic [2:0]  ALT_DIGITS    = 3'd3;
    localparam logic [7:0]  DEGREE_MAX    = 8'd255;
    localparam logic [3:0]  FIX_MAX       = 4'd15;

    localparam logic [31:0] LAT_LIMIT = 32'd900000000;
    localparam logic [31:0] LON_LIMIT = 32'd1800000000;
    localparam logic [29:0] ALT_LIMIT = 30'd1000000000;

    localparam logic [31:0] DIV3_RECIP = 32'hAAAAAAAB;
    localparam int          DIV3_SHIFT = 33;

    typedef struct packed {
        logic        valid;
        logic        is_lon;
        logic [7:0]  deg;
        logic [25:0] x;
    } conv_req_t;

    typedef struct packed {
        logic               emit;
        logic               lat_neg;
        logic               lon_neg;
        logic [3:0]         fix;
        logic signed [30:0] alt_mm;
    } line_info_t;

    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h24;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h4E;
            3'd3:    c = 8'h47;
            3'd4:    c = 8'h47;
            3'd5:    c = 8'h41;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [16:0] frac_step(input logic [2:0] fd, input logic [3:0] d);
        logic [16:0] v;
        case (fd)
            3'd0:    v = 17'(d) * 17'd10000;
            3'd1:    v = 17'(d) * 17'd1000;
            3'd2:    v = 17'(d) * 17'd100;
            3'd3:    v = 17'(d) * 17'd10;
            3'd4:    v = 17'(d);
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic [9:0] alt_step(input logic [2:0] fd, input logic [3:0] d);
        logic [9:0] v;
        case (fd)
            3'd0:    v = 10'(d) * 10'd100;
            3'd1:    v = 10'(d) * 10'd10;
            3'd2:    v = 10'(d);
            default: v = 10'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ngga_field_parser.sv
// Per-byte line and field parser: header match, coordinate digits, hemisphere letters, fix and altitude.
`timescale 1ns / 1ps
`default_nettype none

module ngga_field_parser
    import ngga_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fire,
    input  wire logic [7:0] byte_in,
    output conv_req_t       conv_req,
    output line_info_t      info
);

    logic [4:0]  field_index_reg, field_index_next;
    logic [3:0]  char_cnt_reg, char_cnt_next;
    logic        header_ok_reg, header_ok_next;
    logic [3:0]  min_tens_reg, min_tens_next;
    logic [3:0]  min_ones_reg, min_ones_next;
    logic [7:0]  degree_reg, degree_next;
    logic [16:0] frac5_reg, frac5_next;
    logic [2:0]  frac_digits_reg, frac_digits_next;
    logic        after_dot_reg, after_dot_next;
    logic        stopped_reg, stopped_next;
    logic        lat_present_reg, lat_present_next;
    logic        lon_present_reg, lon_present_next;
    logic        lat_neg_reg, lat_neg_next;
    logic        lon_neg_reg, lon_neg_next;
    logic [3:0]  fix_reg, fix_next;
    logic [29:0] alt_acc_reg, alt_acc_next;
    logic        alt_neg_reg, alt_neg_next;
    conv_req_t   conv_req_reg, conv_req_next;

    logic        is_digit;
    logic [3:0]  digit;
    logic [11:0] deg_wide;
    logic [6:0]  minutes;
    logic [25:0] conv_x;
    logic [7:0]  fix_wide;
    logic [34:0] alt_wide;
    logic        negate;

    assign is_digit = (byte_in >= CHAR_ZERO) && (byte_in <= CHAR_NINE);
    assign digit    = byte_in[3:0];
    assign deg_wide = 12'(degree_reg) * 12'd10 + 12'(min_tens_reg);
    assign minutes  = 7'(min_tens_reg) * 7'd10 + 7'(min_ones_reg);
    assign conv_x   = 26'(minutes) * 26'd500000 + 26'(frac5_reg) * 26'd5 + 26'd1;
    assign fix_wide = 8'(fix_reg) * 8'd10 + 8'(digit);
    assign negate   = (char_cnt_reg == 4'd1) && after_dot_reg;

    always_comb
    begin
        if (!after_dot_reg)
        begin
            alt_wide = 35'(alt_acc_reg) * 35'd10 + 35'(digit) * 35'd1000;
        end
        else if (frac_digits_reg < ALT_DIGITS)
        begin
            alt_wide = 35'(alt_acc_reg) + 35'(alt_step(frac_digits_reg, digit));
        end
        else
        begin
            alt_wide = 35'(alt_acc_reg);
        end
    end

    always_comb
    begin
        field_index_next = field_index_reg;
        char_cnt_next    = char_cnt_reg;
        header_ok_next   = header_ok_reg;
        min_tens_next    = min_tens_reg;
        min_ones_next    = min_ones_reg;
        degree_next      = degree_reg;
        frac5_next       = frac5_reg;
        frac_digits_next = frac_digits_reg;
        after_dot_next   = after_dot_reg;
        stopped_next     = stopped_reg;
        lat_present_next = lat_present_reg;
        lon_present_next = lon_present_reg;
        lat_neg_next     = lat_neg_reg;
        lon_neg_next     = lon_neg_reg;
        fix_next         = fix_reg;
        alt_acc_next     = alt_acc_reg;
        alt_neg_next     = alt_neg_reg;
        conv_req_next    = conv_req_reg;
        conv_req_next.valid = 1'b0;

        if (fire)
        begin
            if (byte_in == CHAR_NL || byte_in == CHAR_COMMA)
            begin
                char_cnt_next    = 4'd0;
                min_tens_next    = 4'd0;
                min_ones_next    = 4'd0;
                degree_next      = 8'd0;
                frac5_next       = 17'd0;
                frac_digits_next = 3'd0;
                after_dot_next   = 1'b0;
                stopped_next     = 1'b0;
            end

            if (byte_in == CHAR_NL)
            begin
                field_index_next = 5'd0;
                header_ok_next   = 1'b1;
                lat_present_next = 1'b0;
                lon_present_next = 1'b0;
                lat_neg_next     = 1'b0;
                lon_neg_next     = 1'b0;
                fix_next         = 4'd0;
                alt_acc_next     = 30'd0;
                alt_neg_next     = 1'b0;
            end
            else if (byte_in == CHAR_COMMA)
            begin
                case (field_index_reg)
                    FLD_HEADER:
                    begin
                        if (char_cnt_reg != HDR_LEN)
                        begin
                            header_ok_next = 1'b0;
                        end
                    end
                    FLD_LAT, FLD_LON:
                    begin
                        conv_req_next.valid  = 1'b1;
                        conv_req_next.is_lon = (field_index_reg == FLD_LON);
                        conv_req_next.deg    = degree_reg;
                        conv_req_next.x      = conv_x;
                        if (field_index_reg == FLD_LON)
                        begin
                            lon_present_next = (char_cnt_reg != 4'd0);
                        end
                        else
                        begin
                            lat_present_next = (char_cnt_reg != 4'd0);
                        end
                    end
                    FLD_LAT_DIR:
                    begin
                        lat_neg_next = negate;
                    end
                    FLD_LON_DIR:
                    begin
                        lon_neg_next = negate;
                    end
                    default:
                    begin
                    end
                endcase
                if (field_index_reg != FLD_MAX)
                begin
                    field_index_next = field_index_reg + 5'd1;
                end
            end
            else
            begin
                case (field_index_reg)
                    FLD_HEADER:
                    begin
                        if (char_cnt_reg >= HDR_LEN || hdr_char(char_cnt_reg[2:0]) != byte_in)
                        begin
                            header_ok_next = 1'b0;
                        end
                    end
                    FLD_LAT, FLD_LON:
                    begin
                        if (!stopped_reg)
                        begin
                            if (is_digit)
                            begin
                                if (after_dot_reg)
                                begin
                                    if (frac_digits_reg < FRAC_DIGITS)
                                    begin
                                        frac5_next = frac5_reg + frac_step(frac_digits_reg, digit);
                                        frac_digits_next = frac_digits_reg + 3'd1;
                                    end
                                end
                                else
                                begin
                                    degree_next = (deg_wide > 12'(DEGREE_MAX)) ? DEGREE_MAX
                                                                               : deg_wide[7:0];
                                    min_tens_next = min_ones_reg;
                                    min_ones_next = digit;
                                end
                            end
                            else if (byte_in == CHAR_DOT && !after_dot_reg)
                            begin
                                after_dot_next = 1'b1;
                            end
                            else
                            begin
                                stopped_next = 1'b1;
                            end
                        end
                    end
                    FLD_LAT_DIR, FLD_LON_DIR:
                    begin
                        if (char_cnt_reg == 4'd0)
                        begin
                            after_dot_next = (byte_in == CHAR_S) || (byte_in == CHAR_W);
                        end
                    end
                    FLD_FIX:
                    begin
                        if (!stopped_reg)
                        begin
                            if (is_digit)
                            begin
                                fix_next = (fix_wide > 8'(FIX_MAX)) ? FIX_MAX : fix_wide[3:0];
                            end
                            else
                            begin
                                stopped_next = 1'b1;
                            end
                        end
                    end
                    FLD_ALT:
                    begin
                        if (!stopped_reg)
                        begin
                            if (is_digit)
                            begin
                                alt_acc_next = (alt_wide > 35'(ALT_LIMIT)) ? ALT_LIMIT
                                                                           : alt_wide[29:0];
                                if (after_dot_reg && frac_digits_reg < ALT_DIGITS)
                                begin
                                    frac_digits_next = frac_digits_reg + 3'd1;
                                end
                            end
                            else if (byte_in == CHAR_DOT && !after_dot_reg)
                            begin
                                after_dot_next = 1'b1;
                            end
                            else if ((byte_in == CHAR_MINUS || byte_in == CHAR_PLUS)
                                     && char_cnt_reg == 4'd0)
                            begin
                                alt_neg_next = (byte_in == CHAR_MINUS);
                            end
                            else
                            begin
                                stopped_next = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (char_cnt_reg != CHAR_CNT_MAX)
                begin
                    char_cnt_next = char_cnt_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_index_reg    <= 5'd0;
            char_cnt_reg       <= 4'd0;
            header_ok_reg      <= 1'b1;
            min_tens_reg       <= 4'd0;
            min_ones_reg       <= 4'd0;
            degree_reg         <= 8'd0;
            frac5_reg          <= 17'd0;
            frac_digits_reg    <= 3'd0;
            after_dot_reg      <= 1'b0;
            stopped_reg        <= 1'b0;
            lat_present_reg    <= 1'b0;
            lon_present_reg    <= 1'b0;
            lat_neg_reg        <= 1'b0;
            lon_neg_reg        <= 1'b0;
            fix_reg            <= 4'd0;
            alt_acc_reg        <= 30'd0;
            alt_neg_reg        <= 1'b0;
            conv_req_reg       <= '0;
        end
        else
        begin
            field_index_reg    <= field_index_next;
            char_cnt_reg       <= char_cnt_next;
            header_ok_reg      <= header_ok_next;
            min_tens_reg       <= min_tens_next;
            min_ones_reg       <= min_ones_next;
            degree_reg         <= degree_next;
            frac5_reg          <= frac5_next;
            frac_digits_reg    <= frac_digits_next;
            after_dot_reg      <= after_dot_next;
            stopped_reg        <= stopped_next;
            lat_present_reg    <= lat_present_next;
            lon_present_reg    <= lon_present_next;
            lat_neg_reg        <= lat_neg_next;
            lon_neg_reg        <= lon_neg_next;
            fix_reg            <= fix_next;
            alt_acc_reg        <= alt_acc_next;
            alt_neg_reg        <= alt_neg_next;
            conv_req_reg       <= conv_req_next;
        end
    end

    assign conv_req     = conv_req_reg;
    assign info.emit    = header_ok_reg && (field_index_reg >= FLD_MIN)
                          && lat_present_reg && lon_present_reg;
    assign info.lat_neg = lat_neg_reg;
    assign info.lon_neg = lon_neg_reg;
    assign info.fix     = fix_reg;
    assign info.alt_mm  = alt_neg_reg ? -$signed({1'b0, alt_acc_reg})
                                      : $signed({1'b0, alt_acc_reg});

endmodule

`default_nettype wire

>>> rtl/ngga_coord_conv.sv
// Coordinate converter: minutes to 1e-7 degree by reciprocal multiply, degree add, clamp.
`timescale 1ns / 1ps
`default_nettype none

module ngga_coord_conv
    import ngga_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire conv_req_t   conv_req,
    output logic      [31:0] lat_mag,
    output logic      [31:0] lon_mag
);

    logic [31:0] lat_held_reg, lat_held_next;
    logic [31:0] lon_held_reg, lon_held_next;
    logic [57:0] product;
    logic [24:0] quotient;
    logic [32:0] value;
    logic [31:0] limit;
    logic [31:0] clamped;

    assign product  = 58'(conv_req.x) * 58'(DIV3_RECIP);
    assign quotient = 25'(product >> DIV3_SHIFT);
    assign value    = 33'(conv_req.deg) * 33'd10000000 + 33'(quotient);
    assign limit    = conv_req.is_lon ? LON_LIMIT : LAT_LIMIT;
    assign clamped  = (value > 33'(limit)) ? limit : value[31:0];

    always_comb
    begin
        lat_held_next = lat_held_reg;
        lon_held_next = lon_held_reg;
        if (conv_req.valid)
        begin
            if (conv_req.is_lon)
            begin
                lon_held_next = clamped;
            end
            else
            begin
                lat_held_next = clamped;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_held_reg <= 32'd0;
            lon_held_reg <= 32'd0;
        end
        else
        begin
            lat_held_reg <= lat_held_next;
            lon_held_reg <= lon_held_next;
        end
    end

    assign lat_mag = lat_held_reg;
    assign lon_mag = lon_held_reg;

endmodule

`default_nettype wire

>>> rtl/nmea_gga_position_parser.sv
// Top level of the GGA position parser: input beat register, parser, converter, result register.
//
//   channel  | dir | beat contents                               | width
//   s_axis   | in  | tdata[7:0] rx_byte                          | 8
//   m_axis   | out | tdata lat, lon, fix, alt (98 bits + pad)    | 104
//
// One byte per cycle while no newline beat stalls; a byte enters the input register and is parsed when it fires.
// A result is loaded into the result register when its newline beat fires from the input register.
// Coordinates convert in the cycle after their closing comma, in a shared multiplier stage.
// Reset clears all line state; no clearing pass is needed.
// Only a newline beat waits while an earlier result is still held; other beats flow on.
`timescale 1ns / 1ps
`default_nettype none

module nmea_gga_position_parser
    import ngga_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic      [103:0] m_axis_tdata    // [30:0] latitude_e7, [62:31] longitude_e7,
                                              // [66:63] fix_quality, [97:67] altitude_mm,
                                              // [103:98] zero
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg, out_valid_next;
    logic [30:0] lat_out_reg;
    logic [31:0] lon_out_reg;
    logic [3:0]  fix_out_reg;
    logic [30:0] alt_out_reg;

    logic        is_nl;
    logic        stall;
    logic        fire;
    logic        load;
    conv_req_t   conv_req;
    line_info_t  info;
    logic [31:0] lat_mag;
    logic [31:0] lon_mag;
    logic [31:0] lat_signed;
    logic [31:0] lon_signed;

    assign is_nl         = (in_byte_reg == CHAR_NL);
    assign stall         = in_valid_reg && is_nl && out_valid_reg && !m_axis_tready;
    assign fire          = in_valid_reg && !stall;
    assign s_axis_tready = !in_valid_reg || !stall;
    assign load          = fire && is_nl && info.emit;

    ngga_field_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .byte_in  (in_byte_reg),
        .conv_req (conv_req),
        .info     (info)
    );

    ngga_coord_conv u_conv (
        .clk      (clk),
        .rst_n    (rst_n),
        .conv_req (conv_req),
        .lat_mag  (lat_mag),
        .lon_mag  (lon_mag)
    );

    assign lat_signed = info.lat_neg ? (32'd0 - lat_mag) : lat_mag;
    assign lon_signed = info.lon_neg ? (32'd0 - lon_mag) : lon_mag;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tready)
        begin
            in_valid_next = s_axis_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (load)
        begin
            lat_out_reg <= lat_signed[30:0];
            lon_out_reg <= lon_signed;
            fix_out_reg <= info.fix;
            alt_out_reg <= info.alt_mm;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, alt_out_reg, fix_out_reg, lon_out_reg, lat_out_reg};

endmodule

`default_nettype wire

>>> rtl/ngga_checker.sv
// Port-level checker for the GGA position parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ngga_checker
    import ngga_pkg::*;
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic [7:0]   s_axis_tdata,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [103:0] m_axis_tdata
);

    logic signed [30:0] lat_e7;
    logic signed [30:0] alt_mm;
    logic               nl_beat;

    assign lat_e7  = $signed(m_axis_tdata[30:0]);
    assign alt_mm  = $signed(m_axis_tdata[97:67]);
    assign nl_beat = s_axis_tvalid && s_axis_tready && (s_axis_tdata == CHAR_NL);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (lat_e7 >= -31'sd900000000) && (lat_e7 <= 31'sd900000000))
        else $error("latitude outside range");

    a_alt_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (alt_mm >= -31'sd1000000000) && (alt_mm <= 31'sd1000000000)
                          && (m_axis_tdata[103:98] == 6'd0))
        else $error("altitude outside range or pad bits set");

    a_result_needs_nl: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(nl_beat, 2))
        else $error("result appeared without a newline beat");

endmodule

bind nmea_gga_position_parser ngga_checker u_ngga_checker (.*);

`default_nettype wire
